// ===== src/assert_macros.svh =====
// Assertion macros shared by the debounce block RTL.
// Included by modules that carry concurrent checks; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define AST_IMPL(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define AST_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/bdsl_pkg.sv =====
// Package for the button debounce block: widths, reset values, codes and types.
// Used by every module of the block; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package bdsl_pkg;

    localparam int unsigned CntW = 8;

    localparam logic [CntW-1:0] DebounceTicksReset = 8'd3;
    localparam logic [CntW-1:0] LongTicksReset     = 8'd200;
    localparam logic [CntW-1:0] HoldMax            = 8'd255;

    // Configuration register indexes.
    localparam logic CFG_DEBOUNCE_TICKS = 1'b0;
    localparam logic CFG_LONG_TICKS     = 1'b1;

    typedef enum logic [1:0] {
        PH_IDLE    = 2'b00,
        PH_PRESSED = 2'b01,
        PH_LONG    = 2'b11
    } t_phase;

    typedef enum logic [1:0] {
        EV_NONE  = 2'd0,
        EV_DOWN  = 2'd1,
        EV_SHORT = 2'd2,
        EV_LONG  = 2'd3
    } t_press_event;

    typedef struct packed {
        t_press_event  press_event;
        logic          mode_flag;
        logic [CntW-1:0] code_number;
    } t_press_result;

endpackage

`default_nettype wire

// ===== src/bdsl_debounce.sv =====
// Debounce filter: holds the debounced key level and its run counter.
// Depends on bdsl_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bdsl_debounce
    import bdsl_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_raw,
    input  wire logic [CntW-1:0] i_bounce_limit,
    output logic                 o_level
);

    logic            r_level;
    logic [CntW-1:0] r_count;
    logic            n_level;
    logic [CntW-1:0] n_count;

    always_comb begin
        n_level = r_level;
        n_count = '0;
        if (i_raw != r_level) begin
            // The count is compared before it advances, so the level follows
            // only after more than the limit of differing samples.
            if (r_count >= i_bounce_limit) begin
                n_level = i_raw;
            end else begin
                n_count = r_count + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_level <= 1'b1;
            r_count <= '0;
        end else if (i_en) begin
            r_level <= n_level;
            r_count <= n_count;
        end
    end

    assign o_level = n_level;

endmodule

`default_nettype wire

// ===== src/bdsl_press_fsm.sv =====
// Press classifier: phase machine, hold counter, mode bit and code index.
// Depends on bdsl_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module bdsl_press_fsm
    import bdsl_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_en,
    input  wire logic            i_level,
    input  wire logic [CntW-1:0] i_long_ticks,
    output t_press_result        o_result
);

    t_phase          r_phase;
    t_phase          n_phase;
    logic [CntW-1:0] r_hold;
    logic [CntW-1:0] n_hold;
    logic            r_mode;
    logic            n_mode;
    logic [CntW-1:0] r_code;
    logic [CntW-1:0] n_code;
    logic [CntW-1:0] hold_inc;
    t_press_event    ev;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
            r_hold  <= '0;
            r_mode  <= 1'b0;
            r_code  <= '0;
        end else if (i_en) begin
            r_phase <= n_phase;
            r_hold  <= n_hold;
            r_mode  <= n_mode;
            r_code  <= n_code;
        end
    end

    // The hold count advances first while a press is in progress.
    assign hold_inc = (r_phase != PH_IDLE && r_hold != HoldMax) ? r_hold + 1'b1 : r_hold;

    always_comb begin
        n_phase = r_phase;
        n_hold  = hold_inc;
        n_mode  = r_mode;
        n_code  = r_code;
        ev      = EV_NONE;
        case (r_phase)
            PH_PRESSED: begin
                if (i_level) begin
                    ev      = EV_SHORT;
                    n_code  = r_code + 1'b1;
                    n_hold  = '0;
                    n_phase = PH_IDLE;
                end else if (hold_inc > i_long_ticks) begin
                    n_phase = PH_LONG;
                end
            end
            PH_LONG: begin
                if (i_level) begin
                    ev      = EV_LONG;
                    n_mode  = ~r_mode;
                    n_code  = '0;
                    n_hold  = '0;
                    n_phase = PH_IDLE;
                end
            end
            default: begin
                n_phase = PH_IDLE;
                if (!i_level) begin
                    ev      = EV_DOWN;
                    n_hold  = '0;
                    n_phase = PH_PRESSED;
                end
            end
        endcase
    end

    assign o_result.press_event = ev;
    assign o_result.mode_flag   = n_mode;
    assign o_result.code_number = n_code;

    `AST_IMPL(a_long_from_armed, i_clk, i_rst_n, i_en && ev == EV_LONG, r_phase == PH_LONG,
        "long release reported outside the long-armed phase")
    `AST_NEXT(a_short_advances_code, i_clk, i_rst_n, i_en && ev == EV_SHORT,
        r_code == $past(r_code) + 1'b1, "short release did not advance the code index")
    `AST_NEXT(a_hold_when_idle, i_clk, i_rst_n, !i_en,
        $stable(r_code) && $stable(r_mode) && $stable(r_phase),
        "press state changed without an item")

endmodule

`default_nettype wire

// ===== src/button_debounce_short_long_press.sv =====
// Channel  | Direction | Handshake              | Payload
// ---------+-----------+------------------------+---------------------------------------------
// in       | input     | i_in_valid/o_in_ready  | i_key_level
// out      | output    | o_out_valid/i_out_ready| o_press_event, o_stable_key, o_mode_flag,
//          |           |                        | o_code_number
// cfg      | input     | i_cfg_we (no wait)     | i_cfg_index, i_cfg_data
//
// One item per cycle sustained while results are taken; an accepted item's result is loaded into
// the result register when the item advances from the input register.
// An item sits in the input register, is classified combinationally and lands in the result register.
// While the result register is full and not taken, the input register holds one item and stalls.
// Reset is synchronous and active low; the thresholds return to 3 and 200 ticks.
// Depends on bdsl_pkg, bdsl_debounce, bdsl_press_fsm and assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module button_debounce_short_long_press
    import bdsl_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_in_valid,
    output logic                 o_in_ready,
    input  wire logic            i_key_level,
    output logic                 o_out_valid,
    input  wire logic            i_out_ready,
    output logic [1:0]           o_press_event,
    output logic                 o_stable_key,
    output logic                 o_mode_flag,
    output logic [CntW-1:0]      o_code_number,
    input  wire logic            i_cfg_we,
    input  wire logic            i_cfg_index,
    input  wire logic [CntW-1:0] i_cfg_data
);

    logic            r_cfg_we_q;
    logic [CntW-1:0] r_dbt;
    logic [CntW-1:0] r_long_ticks;
    logic            r_in_valid;
    logic            r_in_key;
    logic            r_out_valid;
    t_press_result   r_out;
    logic            r_out_key;
    logic            advance;
    logic            level;
    t_press_result   result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dbt        <= DebounceTicksReset;
            r_long_ticks <= LongTicksReset;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_DEBOUNCE_TICKS: r_dbt        <= i_cfg_data;
                CFG_LONG_TICKS:     r_long_ticks <= i_cfg_data;
                default:            r_dbt        <= r_dbt;
            endcase
        end
    end

    // Registered copy of the write strobe, watched by the configuration check below.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_we_q <= 1'b0;
        end else begin
            r_cfg_we_q <= i_cfg_we;
        end
    end

    assign advance    = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready && i_in_valid) begin
            r_in_key <= i_key_level;
        end
    end

    bdsl_debounce u_debounce (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_en           (advance),
        .i_raw          (r_in_key),
        .i_bounce_limit (r_dbt),
        .o_level        (level)
    );

    bdsl_press_fsm u_press_fsm (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_en         (advance),
        .i_level      (level),
        .i_long_ticks (r_long_ticks),
        .o_result     (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out     <= result;
            r_out_key <= level;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_press_event = r_out.press_event;
    assign o_stable_key  = r_out_key;
    assign o_mode_flag   = r_out.mode_flag;
    assign o_code_number = r_out.code_number;

    `AST_NEXT(a_advance_loads_out, i_clk, i_rst_n, advance, r_out_valid,
        "item advanced but the result register is empty")
    `AST_NEXT(a_in_held_on_stall, i_clk, i_rst_n, r_in_valid && !advance,
        r_in_valid && $stable(r_in_key), "stalled item lost from the input register")
    `AST_IMPL(a_no_overwrite, i_clk, i_rst_n, r_out_valid && !i_out_ready, !advance,
        "result overwritten before it was taken")
    `AST_NEXT(a_cfg_strobe, i_clk, i_rst_n, i_cfg_we, r_cfg_we_q,
        "configuration strobe not registered")

endmodule

`default_nettype wire
